// ----- src/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg
// shared widths, types and constants of the smallest-value stream selector
// ----------------------------------------------------------------------------
`default_nettype none

package kss_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KEEP_W  = 5;

    localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 5'd16;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [KEEP_W-1:0]         t_keep;

endpackage : kss_pkg

`default_nettype wire

// ----- src/kss_if.sv -----
// ----------------------------------------------------------------------------
// kss channel interfaces
// valid/ready channels for samples, kept results and the keep_count write
// ----------------------------------------------------------------------------
`default_nettype none

interface kss_sample_if import kss_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value sample_value;
    logic   is_final;

    modport source (output valid, output sample_value, output is_final, input ready);
    modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface : kss_sample_if

interface kss_kept_if import kss_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value kept_value;
    logic   run_end;

    modport source (output valid, output kept_value, output run_end, input ready);
    modport sink   (input valid, input kept_value, input run_end, output ready);
endinterface : kss_kept_if

interface kss_cfg_if import kss_pkg::*; ();
    logic  valid;
    logic  ready;
    t_keep keep_count;

    modport source (output valid, output keep_count, input ready);
    modport sink   (input valid, input keep_count, output ready);
endinterface : kss_cfg_if

`default_nettype wire

// ----- src/k_smallest_stream_select_unit.sv -----
// ----------------------------------------------------------------------------
// k_smallest_stream_select_unit
// keeps the keep_count smallest signed samples of a stream, reports them
// ascending after the final sample
// ----------------------------------------------------------------------------
// throughput: one sample transfer per cycle, set by the single-pass row of
//   compare-and-shift cells; a final sample waits in the input register while
//   the previous run still drains (one result per cycle while the sink is ready, up to keep_count)
// result path: the final sample moves from the input register into the drain
//   bank, which then offers the run's results one per cycle as the sink takes them
// reset: keep_count back to 16, fill count and valid flags clear, cells undefined
`default_nettype none

module k_smallest_stream_select_unit
    import kss_pkg::*;
#(
    parameter int unsigned K_MAX = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    kss_sample_if.sink   i_sample,
    kss_kept_if.source   o_kept,
    kss_cfg_if.sink      i_cfg
);

    // fill count must hold K_MAX itself
    localparam int unsigned CW = $clog2(K_MAX + 1);

    // configuration
    t_keep r_keep_count;
    logic  [CW-1:0] eff_k;

    // input register stage
    logic   r_in_valid;
    t_value r_in_value;
    logic   r_in_final;
    logic   in_advance;

    // sorted row of kept values
    t_value r_cells [K_MAX];
    t_value n_cells [K_MAX];
    logic   [CW-1:0] r_fill;
    logic   [CW-1:0] n_fill;
    logic   [CW-1:0] cur_fill;

    // per-cell compare results
    logic [K_MAX-1:0] lt_vec;      // sample below cell value
    logic [K_MAX-1:0] occ_vec;     // cell holds a kept value
    logic [K_MAX-1:0] stay_vec;    // cell keeps its value (sample goes above it)
    logic             table_full;
    logic             admit;

    // drain bank, result always read from entry 0
    t_value r_drain [K_MAX];
    logic   [CW-1:0] r_drain_cnt;
    logic   out_xfer;
    logic   drain_free;
    logic   load_drain;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_keep_count <= i_cfg.keep_count;
        end
    end

    // zero counts as one, anything above the row depth saturates
    always_comb begin
        if (r_keep_count == '0) begin
            eff_k = CW'(1);
        end else if (32'(r_keep_count) > 32'(K_MAX)) begin
            eff_k = CW'(K_MAX);
        end else begin
            eff_k = CW'(r_keep_count);
        end
    end

    // ---------------------------------------------------------- handshakes
    assign out_xfer   = o_kept.valid && o_kept.ready;
    // drain bank is free if empty or its last result leaves this cycle
    assign drain_free = (r_drain_cnt == '0) || ((r_drain_cnt == CW'(1)) && out_xfer);
    // a final sample must wait for the drain bank, any other goes straight in
    assign in_advance = r_in_valid && (!r_in_final || drain_free);
    assign load_drain = in_advance && r_in_final;

    assign i_sample.ready = !r_in_valid || in_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_in_value <= i_sample.sample_value;
            r_in_final <= i_sample.is_final;
        end
    end

    // -------------------------------------------------------- insertion row
    // a lowered keep_count cuts the row before the insertion
    assign cur_fill   = (r_fill > eff_k) ? eff_k : r_fill;
    assign table_full = (cur_fill == eff_k);
    // row is sorted, so the sample is admitted to a full row iff it is
    // below some occupied cell, i.e. below the largest one
    assign admit      = !table_full || |(lt_vec & occ_vec);

    for (genvar gi = 0; gi < K_MAX; gi++) begin : g_cell
        assign lt_vec[gi]   = r_in_value < r_cells[gi];
        assign occ_vec[gi]  = CW'(gi) < cur_fill;
        // equal values stay below the new sample
        assign stay_vec[gi] = occ_vec[gi] && !lt_vec[gi];

        if (gi == 0) begin : g_first
            always_comb begin
                if (stay_vec[gi]) begin
                    n_cells[gi] = r_cells[gi];
                end else begin
                    n_cells[gi] = r_in_value;
                end
            end
        end else begin : g_rest
            // sample lands here if the cell below stays, else shift up
            always_comb begin
                if (stay_vec[gi]) begin
                    n_cells[gi] = r_cells[gi];
                end else if (stay_vec[gi-1]) begin
                    n_cells[gi] = r_in_value;
                end else begin
                    n_cells[gi] = r_cells[gi-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (in_advance && admit) begin
                r_cells[gi] <= n_cells[gi];
            end
        end
    end

    assign n_fill = table_full ? eff_k : cur_fill + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (load_drain) begin
            // row handed over to the drain bank, next run starts empty
            r_fill <= '0;
        end else if (in_advance) begin
            r_fill <= n_fill;
        end
    end

    // ----------------------------------------------------------- drain bank
    for (genvar gd = 0; gd < K_MAX; gd++) begin : g_drain
        if (gd == K_MAX - 1) begin : g_top
            always_ff @(posedge i_clk) begin
                if (load_drain) begin
                    r_drain[gd] <= admit ? n_cells[gd] : r_cells[gd];
                end
            end
        end else begin : g_low
            always_ff @(posedge i_clk) begin
                if (load_drain) begin
                    r_drain[gd] <= admit ? n_cells[gd] : r_cells[gd];
                end else if (out_xfer) begin
                    r_drain[gd] <= r_drain[gd+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_cnt <= '0;
        end else if (load_drain) begin
            r_drain_cnt <= n_fill;
        end else if (out_xfer) begin
            r_drain_cnt <= r_drain_cnt - CW'(1);
        end
    end

    assign o_kept.valid      = (r_drain_cnt != '0);
    assign o_kept.kept_value = r_drain[0];
    assign o_kept.run_end    = (r_drain_cnt == CW'(1));

endmodule : k_smallest_stream_select_unit

`default_nettype wire

// ----- verif/k_smallest_stream_select_unit_tb.sv -----
// ----------------------------------------------------------------------------
// k_smallest_stream_select_unit_tb
// drives sample streams into the selector, predicts the kept values of
// every run in a scoreboard and compares each kept transfer field by field,
// with random idling on both sides, keep_count changes between and inside
// streams, a long output stall and a full drain pause
// ----------------------------------------------------------------------------
`default_nettype none

module k_smallest_stream_select_unit_tb import kss_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned K_MAX       = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEM_TARGET = 450;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE      = 8;

    localparam t_value MOST_NEG = 32'sh8000_0000;
    localparam t_value MOST_POS = 32'sh7FFF_FFFF;

    typedef struct {
        t_value value;
        logic   run_end;
    } t_kept_item;

    // predicts the ascending kept values of each run and checks them
    class kept_scoreboard;
        t_keep      keep_reg;
        t_value     cells[K_MAX];
        int         fill;
        t_kept_item pending_kept[$];
        int         mismatches;

        function new();
            keep_reg   = KEEP_COUNT_RESET;
            fill       = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function void set_keep(t_keep k);
            keep_reg = k;
        endfunction

        function int pending();
            return pending_kept.size();
        endfunction

        // zero acts as one, anything above the table depth saturates
        function int keep_limit();
            if (keep_reg == 0) return 1;
            if (keep_reg > K_MAX) return K_MAX;
            return int'(keep_reg);
        endfunction

        // compare-and-shift insertion, equal values land after the kept ones
        function void insert_sorted(t_value v, int k);
            int pos;
            pos = 0;
            if (fill >= k) begin
                fill = k;
                if (!(v < cells[k-1])) return;
                fill = k - 1;
            end
            while (pos < fill && !(v < cells[pos])) pos++;
            for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = v;
            fill++;
        endfunction

        function void take_sample(t_value v, logic fin);
            int         k;
            t_kept_item item;
            k = keep_limit();
            // a lowered keep_count drops the largest kept values first
            if (fill > k) fill = k;
            insert_sorted(v, k);
            if (fin) begin
                for (int i = 0; i < fill; i++) begin
                    item.value   = cells[i];
                    item.run_end = (i == fill - 1);
                    pending_kept.push_back(item);
                end
                fill = 0;
            end
        endfunction

        task check_kept(t_value got_value, logic got_end);
            t_kept_item want;
            if (pending_kept.size() == 0) begin
                report($sformatf("kept value %0d arrived with nothing outstanding",
                                 got_value));
                return;
            end
            want = pending_kept.pop_front();
            if (got_value !== want.value)
                report($sformatf("kept_value %0d, predicted %0d", got_value, want.value));
            if (got_end !== want.run_end)
                report($sformatf("run_end %0b on value %0d, predicted %0b",
                                 got_end, got_value, want.run_end));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    kss_sample_if sample_ch ();
    kss_kept_if   kept_ch ();
    kss_cfg_if    cfg_ch ();

    k_smallest_stream_select_unit #(
        .K_MAX (K_MAX)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_kept   (kept_ch),
        .i_cfg    (cfg_ch)
    );

    kept_scoreboard sb;

    int unsigned cycle_count;
    int unsigned samples_taken;
    int unsigned streams_taken;
    int unsigned results_checked;
    int unsigned keep_writes;
    bit          idle_on;
    bit          long_hold_req;
    bit          rx_enable;

    always #5 i_clk = ~i_clk;

    // watchdog: a run that never drains ends here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cycle limit of %0d reached", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // transfer monitor: kept results checked before the same edge's sample is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (kept_ch.valid && kept_ch.ready) begin
                sb.check_kept(kept_ch.kept_value, kept_ch.run_end);
                results_checked++;
            end
            if (sample_ch.valid && sample_ch.ready) begin
                sb.take_sample(sample_ch.sample_value, sample_ch.is_final);
                samples_taken++;
                if (sample_ch.is_final) streams_taken++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.set_keep(cfg_ch.keep_count);
                keep_writes++;
            end
        end
    end

    // result side: random stall bursts, plus one long hold on request
    initial begin
        kept_ch.ready <= 1'b0;
        wait (rx_enable);
        forever begin
            if (long_hold_req) begin
                kept_ch.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                kept_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            kept_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // one sample transfer, then maybe a gap with valid low
    task send_sample(t_value v, logic fin);
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.is_final     <= fin;
        do @(posedge i_clk); while (!sample_ch.ready);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // sender pauses until every predicted result is back, then lets the block settle;
    // it first lets the monitor note the last sample transfer
    task wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_keep(t_keep k);
        wait_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.keep_count <= k;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // extremes often, small values for ties, otherwise the full range
    function t_value pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return t_value'(int'($urandom_range(0, 16)) - 8);
            default: return t_value'($urandom);
        endcase
    endfunction

    function t_keep pick_keep();
        case ($urandom_range(0, 5))
            0: return t_keep'(1);
            1: return t_keep'(K_MAX);
            2: return '0;
            3: return '1;
            default: return t_keep'($urandom_range(0, 31));
        endcase
    endfunction

    task run_directed();
        // reset keep_count, single most-negative final sample
        send_sample(MOST_NEG, 1'b1);
        // extremes with ties, final value equal to kept ones
        send_sample(MOST_POS, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample(t_value'(5), 1'b0);
        send_sample(MOST_NEG, 1'b0);
        send_sample(t_value'(5), 1'b0);
        send_sample(t_value'(5), 1'b1);
        // full table: larger value dropped, tie with the largest not admitted
        write_keep(t_keep'(3));
        send_sample(t_value'(10), 1'b0);
        send_sample(t_value'(20), 1'b0);
        send_sample(t_value'(30), 1'b0);
        send_sample(t_value'(40), 1'b0);
        send_sample(t_value'(30), 1'b0);
        send_sample(t_value'(5), 1'b1);
        // zero keep_count acts as one
        write_keep('0);
        send_sample(t_value'(7), 1'b0);
        send_sample(t_value'(3), 1'b1);
        // saturated keep_count, then lowered mid-stream
        write_keep('1);
        send_sample(t_value'(4), 1'b0);
        send_sample(t_value'(3), 1'b0);
        send_sample(t_value'(2), 1'b0);
        send_sample(t_value'(1), 1'b0);
        write_keep(t_keep'(2));
        send_sample(t_value'(9), 1'b1);
    endtask

    // output held off while several runs queue up, so the input must stall
    task run_pressure();
        write_keep(t_keep'(K_MAX));
        long_hold_req = 1'b1;
        for (int s = 0; s < 4; s++) begin
            for (int i = 0; i < 6; i++) send_sample(pick_value(), i == 5);
        end
        wait_drained();
    endtask

    task run_random();
        int len;
        int mid;
        while (samples_taken < ITEM_TARGET) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            mid = ($urandom_range(0, 9) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
            if ($urandom_range(0, 3) == 0) write_keep(pick_keep());
            for (int i = 0; i < len; i++) begin
                if (mid != 0 && i == mid) write_keep(pick_keep());
                send_sample(pick_value(), i == len - 1);
            end
            // last stretch runs without idling on either side
            if (samples_taken + 80 > ITEM_TARGET) idle_on = 1'b0;
        end
    endtask

    initial begin
        sb = new();
        samples_taken   = 0;
        streams_taken   = 0;
        results_checked = 0;
        keep_writes     = 0;
        idle_on         = 1'b1;
        long_hold_req   = 1'b0;
        rx_enable       = 1'b0;
        i_rst_n                <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.is_final     <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.keep_count      <= KEEP_COUNT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_enable = 1'b1;

        run_directed();
        run_pressure();
        run_random();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d samples in %0d streams, %0d kept results compared",
                 samples_taken, streams_taken, results_checked);
        $display("%0d keep_count writes, one long output hold, %0d mismatches",
                 keep_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule : k_smallest_stream_select_unit_tb

`default_nettype wire
